>>> hw/rtl/pf_pkg.sv
// ----------------------------------------------------------------------------
// pf_pkg
// Shared types, codes and square geometry helpers for the Playfair block.
// ----------------------------------------------------------------------------
package pf_pkg;

  // square geometry
  localparam int SIDE    = 5;
  localparam int CELLS   = SIDE * SIDE;
  localparam int LETTERS = 26;
  localparam int CODE_W  = 5;
  localparam int RC_W    = 3;

  localparam logic [CODE_W-1:0] CODE_I = 5'd8;
  localparam logic [CODE_W-1:0] CODE_J = 5'd9;
  localparam logic [CODE_W-1:0] FILL_FULL = 5'(CELLS);
  localparam logic [CODE_W-1:0] LAST_LETTER = 5'(LETTERS - 1);

  // ascii bounds
  localparam logic [7:0] ASC_UP_A = 8'h41;
  localparam logic [7:0] ASC_UP_Z = 8'h5a;
  localparam logic [7:0] ASC_LO_A = 8'h61;
  localparam logic [7:0] ASC_LO_Z = 8'h7a;
  localparam logic [7:0] ASC_CASE = 8'h20;
  localparam logic [6:0] ASC_A7   = 7'h41;

  // operation codes
  localparam logic [2:0] OP_START  = 3'd0;
  localparam logic [2:0] OP_KEY    = 3'd1;
  localparam logic [2:0] OP_FINISH = 3'd2;
  localparam logic [2:0] OP_ENC    = 3'd3;
  localparam logic [2:0] OP_DEC    = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_LETTER = 2'd1;
  localparam logic [1:0] ST_NOT_READY  = 2'd2;
  localparam logic [1:0] ST_IGNORED    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_POS_B,
    S_MAP,
    S_SQ_B,
    S_OUT
  } pf_state_t;

  // row of a square position
  function automatic logic [RC_W-1:0] pos_row(input logic [CODE_W-1:0] p);
    logic [RC_W-1:0] r;
    if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  // position from row and column
  function automatic logic [CODE_W-1:0] rc_pos(input logic [RC_W-1:0] row,
                                               input logic [RC_W-1:0] col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

  // column of a square position
  function automatic logic [RC_W-1:0] pos_col(input logic [CODE_W-1:0] p);
    logic [CODE_W-1:0] base;
    base = rc_pos(pos_row(p), 3'd0);
    return RC_W'(p - base);
  endfunction

  // step one place along a row or column, wrapping
  function automatic logic [RC_W-1:0] step_rc(input logic [RC_W-1:0] v,
                                              input logic dec);
    logic [RC_W-1:0] s;
    if (dec) s = (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
    else s = (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
    return s;
  endfunction

endpackage

>>> hw/rtl/pf_ram.sv
// ----------------------------------------------------------------------------
// pf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/playfair_digram_cipher.sv
// ----------------------------------------------------------------------------
// playfair_digram_cipher
// Playfair key square builder and digram encrypt/decrypt engine.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; each item yields
// exactly one result, shown for one cycle with out_valid, the cycle after
// the item's work ends, and the receiver cannot stall it. Start key, key
// byte and unknown operations finish at once, so such items can be issued
// every cycle. A finish key on a square that is not yet ready walks the 26
// letters one per cycle. A digram's two position lookups and its two square
// lookups go one at a time through the single read port of the position
// table and of the square table. A digram that is rejected (square not ready,
// bad letter) finishes at once.
module playfair_digram_cipher
  import pf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_letter_a,
  input  logic [7:0] in_letter_b,
  output logic       out_valid,
  output logic [6:0] out_a,
  output logic [6:0] out_b,
  output logic [1:0] out_status
);

  localparam int CELL_AW = $clog2(CELLS);
  localparam int LTR_AW  = $clog2(LETTERS);

  pf_state_t state_r, state_nxt;

  logic [LETTERS-1:0] used_r, used_nxt;
  logic [CODE_W-1:0]  fill_r, fill_nxt;
  logic               ready_r, ready_nxt;
  logic [CODE_W-1:0]  cnt_r, cnt_nxt;
  logic [CODE_W-1:0]  cb_r, cb_nxt;
  logic               dec_r, dec_nxt;
  logic [CODE_W-1:0]  pa_r, pa_nxt;
  logic [CODE_W-1:0]  tb_r, tb_nxt;
  logic [CODE_W-1:0]  la_r, la_nxt;

  logic       out_valid_r;
  logic [6:0] out_a_r, out_b_r;
  logic [1:0] out_status_r;

  logic       res_valid;
  logic [6:0] res_a, res_b;
  logic [1:0] res_st;

  logic                accept;
  logic [7:0]          key_ch;
  logic                key_letter;
  logic [CODE_W-1:0]   key_code;
  logic                a_ok, b_ok;
  logic [CODE_W-1:0]   ca_code, cb_code;
  logic                is_digram;

  // table ports
  logic                pos_we, sq_we;
  logic [LTR_AW-1:0]   pos_waddr, pos_raddr;
  logic [CELL_AW-1:0]  sq_waddr, sq_raddr;
  logic [CODE_W-1:0]   pos_wdata, sq_wdata, pos_rdata, sq_rdata;

  // shared position unit
  logic [RC_W-1:0] r1, c1, r2, c2, ra, ca_col, rb, cb_col;
  logic [CODE_W-1:0] ta, tb;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign is_digram = (in_operation == OP_ENC) || (in_operation == OP_DEC);

  // key byte: fold case and J
  always_comb begin
    key_ch = in_letter_a;
    if (in_letter_a >= ASC_LO_A && in_letter_a <= ASC_LO_Z) begin
      key_ch = in_letter_a - ASC_CASE;
    end
    key_letter = (key_ch >= ASC_UP_A) && (key_ch <= ASC_UP_Z);
    key_code   = CODE_W'(key_ch - ASC_UP_A);
    if (key_code == CODE_J) begin
      key_code = CODE_I;
    end
  end

  // digram letters: uppercase only, J read as I
  always_comb begin
    a_ok    = (in_letter_a >= ASC_UP_A) && (in_letter_a <= ASC_UP_Z);
    b_ok    = (in_letter_b >= ASC_UP_A) && (in_letter_b <= ASC_UP_Z);
    ca_code = CODE_W'(in_letter_a - ASC_UP_A);
    cb_code = CODE_W'(in_letter_b - ASC_UP_A);
    if (ca_code == CODE_J) ca_code = CODE_I;
    if (cb_code == CODE_J) cb_code = CODE_I;
  end

  // digram rule on the two positions
  always_comb begin
    r1 = pos_row(pa_r);
    c1 = pos_col(pa_r);
    r2 = pos_row(pos_rdata);
    c2 = pos_col(pos_rdata);
    if (r1 == r2) begin
      ra = r1; ca_col = step_rc(c1, dec_r);
      rb = r2; cb_col = step_rc(c2, dec_r);
    end else if (c1 == c2) begin
      ra = step_rc(r1, dec_r); ca_col = c1;
      rb = step_rc(r2, dec_r); cb_col = c2;
    end else begin
      ra = r1; ca_col = c2;
      rb = r2; cb_col = c1;
    end
    ta = rc_pos(ra, ca_col);
    tb = rc_pos(rb, cb_col);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_FINISH && !ready_r) begin
            state_nxt = S_FILL;
          end else if (is_digram && ready_r && a_ok && b_ok) begin
            state_nxt = S_POS_B;
          end
        end
      end
      S_FILL:  if (cnt_r == LAST_LETTER) state_nxt = S_IDLE;
      S_POS_B: state_nxt = S_MAP;
      S_MAP:   state_nxt = S_SQ_B;
      S_SQ_B:  state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and table control
  always_comb begin
    used_nxt  = used_r;
    fill_nxt  = fill_r;
    ready_nxt = ready_r;
    cnt_nxt   = cnt_r;
    cb_nxt    = cb_r;
    dec_nxt   = dec_r;
    pa_nxt    = pa_r;
    tb_nxt    = tb_r;
    la_nxt    = la_r;
    pos_we    = 1'b0;
    sq_we     = 1'b0;
    pos_waddr = key_code;
    pos_wdata = fill_r;
    sq_waddr  = fill_r;
    sq_wdata  = key_code;
    pos_raddr = ca_code;
    sq_raddr  = ta;
    res_valid = 1'b0;
    res_a     = '0;
    res_b     = '0;
    res_st    = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_START: begin
              res_valid = 1'b1;
              used_nxt  = LETTERS'(1) << CODE_J;
              fill_nxt  = '0;
              ready_nxt = 1'b0;
            end
            OP_KEY: begin
              res_valid = 1'b1;
              if (ready_r || !key_letter || used_r[key_code]) begin
                res_st = ST_IGNORED;
              end else if (fill_r < FILL_FULL) begin
                pos_we             = 1'b1;
                sq_we              = 1'b1;
                used_nxt[key_code] = 1'b1;
                fill_nxt           = fill_r + 5'd1;
              end
            end
            OP_FINISH: begin
              cnt_nxt = '0;
              if (ready_r) res_valid = 1'b1;
            end
            OP_ENC, OP_DEC: begin
              if (!ready_r) begin
                res_valid = 1'b1;
                res_st    = ST_NOT_READY;
              end else if (!a_ok || !b_ok) begin
                res_valid = 1'b1;
                res_st    = ST_BAD_LETTER;
              end else begin
                cb_nxt  = cb_code;
                dec_nxt = (in_operation == OP_DEC);
              end
            end
            default: res_valid = 1'b1;
          endcase
        end
      end
      // append unused letters in order
      S_FILL: begin
        pos_waddr = cnt_r;
        sq_wdata  = cnt_r;
        if (!used_r[cnt_r] && fill_r < FILL_FULL) begin
          pos_we          = 1'b1;
          sq_we           = 1'b1;
          used_nxt[cnt_r] = 1'b1;
          fill_nxt        = fill_r + 5'd1;
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST_LETTER) begin
          ready_nxt = 1'b1;
          res_valid = 1'b1;
        end
      end
      S_POS_B: begin
        pa_nxt    = pos_rdata;
        pos_raddr = cb_r;
      end
      S_MAP: begin
        sq_raddr = ta;
        tb_nxt   = tb;
      end
      S_SQ_B: begin
        la_nxt   = sq_rdata;
        sq_raddr = tb_r;
      end
      S_OUT: begin
        res_valid = 1'b1;
        res_a     = ASC_A7 + {2'b00, la_r};
        res_b     = ASC_A7 + {2'b00, sq_rdata};
      end
      default: res_valid = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= LETTERS'(1) << CODE_J;
      fill_r      <= '0;
      ready_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      ready_r     <= ready_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= res_valid;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cb_r  <= cb_nxt;
    dec_r <= dec_nxt;
    pa_r  <= pa_nxt;
    tb_r  <= tb_nxt;
    la_r  <= la_nxt;
    if (res_valid) begin
      out_a_r      <= res_a;
      out_b_r      <= res_b;
      out_status_r <= res_st;
    end
  end

  // letter to square position
  pf_ram #(
    .WIDTH(CODE_W),
    .DEPTH(LETTERS)
  ) u_pos_ram (
    .clk  (clk),
    .we   (pos_we),
    .waddr(pos_waddr),
    .wdata(pos_wdata),
    .raddr(pos_raddr),
    .rdata(pos_rdata)
  );

  // square position to letter
  pf_ram #(
    .WIDTH(CODE_W),
    .DEPTH(CELLS)
  ) u_sq_ram (
    .clk  (clk),
    .we   (sq_we),
    .waddr(sq_waddr),
    .wdata(sq_wdata),
    .raddr(sq_raddr),
    .rdata(sq_rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_a      = out_a_r;
  assign out_b      = out_b_r;
  assign out_status = out_status_r;

  // a result only ever follows the end of an item's work
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result strobe while sequencer busy");

  // the square never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill count beyond square size");

  // a finished square is full
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ready_r) |-> fill_r == FILL_FULL)
    else $error("square marked ready while not full");

  // the last digram step always produces a result
  a_out_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |=> out_valid_r)
    else $error("digram result missing");

endmodule
